FILE: rtl/core/glyph_bitmap_rotated_blit_unit_defines.svh
// Assertion macros for the glyph blit unit.
// Included by the top level only; no other dependencies.
`ifndef GLYPH_BITMAP_ROTATED_BLIT_UNIT_DEFINES_SVH
`define GLYPH_BITMAP_ROTATED_BLIT_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define GBRB_ASSERT_IMPL(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

// next-cycle implication, checked during reset too
`define GBRB_ASSERT_NEXT(label, clk, a, b) \
  label: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/gbrb_pkg.sv
// Shared types, constants and arithmetic helpers of the glyph blit unit.
// No dependencies.
`timescale 1ns / 1ps
package gbrb_pkg;

  localparam int FRAC_BITS = 14;
  localparam int MAX_COLS  = 64;
  localparam int ACC_W     = 36;

  localparam logic signed [15:0] UNIT_ONE = 16'sd16384;
  localparam logic signed [ACC_W-1:0] TRUNC_BIAS = (ACC_W'(1) <<< FRAC_BITS) - ACC_W'(1);

  typedef enum logic [1:0] {
    OP_SET_PEN = 2'd0,
    OP_HEADER  = 2'd1,
    OP_ROW     = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    DIR_RIGHT = 3'd0,
    DIR_UP    = 3'd1,
    DIR_LEFT  = 3'd2,
    DIR_DOWN  = 3'd3,
    DIR_ANGLE = 3'd4
  } dir_t;

  typedef enum logic [1:0] {
    CFG_DIRECTION = 2'd0,
    CFG_COS       = 2'd1,
    CFG_SIN       = 2'd2
  } cfg_idx_t;

  // one row of work for the back end
  typedef struct packed {
    logic signed [ACC_W-1:0] x;
    logic signed [ACC_W-1:0] y;
    logic signed [15:0]      c;
    logic signed [15:0]      s;
    logic [63:0]             bits;
  } job_t;

  function automatic logic signed [15:0] unit_c(input logic [2:0] dir,
                                                input logic signed [15:0] cq);
    logic signed [15:0] r;
    r = '0;
    if (dir == DIR_ANGLE) begin
      r = cq;
    end else begin
      case (dir[1:0])
        2'd0:    r = UNIT_ONE;
        2'd2:    r = -UNIT_ONE;
        default: r = '0;
      endcase
    end
    return r;
  endfunction

  function automatic logic signed [15:0] unit_s(input logic [2:0] dir,
                                                input logic signed [15:0] sq);
    logic signed [15:0] r;
    r = '0;
    if (dir == DIR_ANGLE) begin
      r = sq;
    end else begin
      case (dir[1:0])
        2'd1:    r = UNIT_ONE;
        2'd3:    r = -UNIT_ONE;
        default: r = '0;
      endcase
    end
    return r;
  endfunction

  // truncate toward zero to an integer, wrap to 16 bits
  function automatic logic [15:0] to_coord(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] b;
    logic signed [ACC_W-1:0] t;
    b = v + (v[ACC_W-1] ? TRUNC_BIAS : '0);
    t = b >>> FRAC_BITS;
    return t[15:0];
  endfunction

endpackage

FILE: rtl/core/gbrb_front.sv
// Front end: accepts items, keeps pen, base and row state, builds row jobs.
// Depends on gbrb_pkg.
`timescale 1ns / 1ps
module gbrb_front import gbrb_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         op,
  input  logic signed [15:0] pen_x,
  input  logic signed [15:0] pen_y,
  input  logic signed [7:0]  extent_left,
  input  logic signed [7:0]  extent_right,
  input  logic signed [7:0]  extent_up,
  input  logic signed [7:0]  extent_down,
  input  logic signed [15:0] advance,
  input  logic [63:0]        row_bits,
  input  logic signed [15:0] vec_c,
  input  logic signed [15:0] vec_s,
  output logic               job_push,
  output job_t               job,
  input  logic               fifo_full
);

  // product stage
  logic               vb_r;
  logic [1:0]         op_b_r;
  logic signed [15:0] pen_x_b_r, pen_y_b_r;
  logic signed [31:0] p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;
  logic [63:0]        bits_b_r;
  logic signed [15:0] c_b_r, s_b_r;
  logic               rowok_b_r;

  logic [8:0] row_index_r, row_total_r;
  logic [6:0] col_total_r;

  // sum stage state
  logic signed [15:0]      pen_x_r, pen_y_r;
  logic signed [ACC_W-1:0] base_fx_r, base_fy_r;

  logic accept, c_fire, rowok;
  logic signed [8:0] rows, cols;
  logic signed [9:0] r_s;
  logic [63:0] col_mask;
  logic signed [ACC_W-1:0] px, py, pen_fx, pen_fy;

  assign accept   = in_valid && in_ready;
  assign rowok    = row_index_r < row_total_r;
  assign rows     = 9'(extent_up) + 9'(extent_down);
  assign cols     = 9'(extent_left) + 9'(extent_right);
  assign r_s      = signed'({1'b0, row_index_r});
  assign col_mask = ~({64{1'b1}} >> col_total_r);

  assign px     = ACC_W'(pen_x_r) <<< FRAC_BITS;
  assign py     = ACC_W'(pen_y_r) <<< FRAC_BITS;
  assign pen_fx = px + ACC_W'(p4_r);
  assign pen_fy = py + ACC_W'(p5_r);

  assign job_push = vb_r && (op_b_r == OP_ROW) && rowok_b_r && (bits_b_r != '0) && !fifo_full;
  assign c_fire   = vb_r && !((op_b_r == OP_ROW) && rowok_b_r && (bits_b_r != '0) && fifo_full);
  assign in_ready = !vb_r || c_fire;

  assign job.x    = base_fx_r + ACC_W'(p0_r);
  assign job.y    = base_fy_r - ACC_W'(p1_r);
  assign job.c    = c_b_r;
  assign job.s    = s_b_r;
  assign job.bits = bits_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r        <= 1'b0;
      row_index_r <= '0;
      row_total_r <= '0;
      col_total_r <= '0;
    end else begin
      if (in_ready) vb_r <= in_valid;
      if (accept && op == OP_HEADER) begin
        row_index_r <= '0;
        row_total_r <= (rows > 9'sd0) ? rows : '0;
        if (cols < 9'sd0)            col_total_r <= '0;
        else if (cols > 9'sd64)      col_total_r <= 7'(MAX_COLS);
        else                         col_total_r <= cols[6:0];
      end else if (accept && op == OP_ROW && rowok) begin
        row_index_r <= row_index_r + 9'd1;
      end
    end
  end

  // product stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_b_r    <= op;
      pen_x_b_r <= pen_x;
      pen_y_b_r <= pen_y;
      c_b_r     <= vec_c;
      s_b_r     <= vec_s;
      rowok_b_r <= rowok;
      bits_b_r  <= row_bits & col_mask;
      if (op == OP_ROW) begin
        p0_r <= 32'(r_s * vec_s);
        p1_r <= 32'(r_s * vec_c);
      end else begin
        p0_r <= 32'(vec_c * extent_left);
        p1_r <= 32'(vec_s * extent_up);
      end
      p2_r <= 32'(vec_s * extent_left);
      p3_r <= 32'(vec_c * extent_up);
      p4_r <= 32'(vec_c * advance);
      p5_r <= 32'(vec_s * advance);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r   <= '0;
      pen_y_r   <= '0;
      base_fx_r <= '0;
      base_fy_r <= '0;
    end else if (c_fire) begin
      case (op_b_r)
        OP_SET_PEN: begin
          pen_x_r <= pen_x_b_r;
          pen_y_r <= pen_y_b_r;
        end
        OP_HEADER: begin
          base_fx_r <= px - ACC_W'(p0_r) - ACC_W'(p1_r);
          base_fy_r <= py - ACC_W'(p2_r) + ACC_W'(p3_r);
          pen_x_r   <= to_coord(pen_fx);
          pen_y_r   <= to_coord(pen_fy);
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/gbrb_fifo.sv
// Two-entry job queue between front and back ends.
// Depends on gbrb_pkg.
`timescale 1ns / 1ps
module gbrb_fifo import gbrb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic empty,
  output logic full
);

  job_t       mem_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;

  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'd2);
  assign head  = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (pop)  rd_r <= ~rd_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

FILE: rtl/core/gbrb_back.sv
// Back end: walks a row job one column per cycle, a set column waiting for a free output, and emits set pixels.
// Depends on gbrb_pkg.
`timescale 1ns / 1ps
module gbrb_back import gbrb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  job_t        head,
  input  logic        empty,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_x,
  output logic [15:0] out_y,
  output logic        out_last
);

  logic signed [ACC_W-1:0] x_r, y_r;
  logic signed [15:0]      c_r, s_r;
  logic [63:0]             bits_r;
  logic                    ov_r;
  logic [15:0]             ox_r, oy_r;
  logic                    olast_r;

  logic busy, out_free, advance, emit, done;
  logic [63:0] bits_nxt;

  assign busy     = bits_r != '0;
  assign out_free = !ov_r || out_ready;
  assign advance  = busy && (!bits_r[63] || out_free);
  assign emit     = advance && bits_r[63];
  assign bits_nxt = bits_r << 1;
  assign done     = !busy || (advance && bits_nxt == '0);
  assign pop      = done && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      if (pop)          bits_r <= head.bits;
      else if (advance) bits_r <= bits_nxt;
      if (emit)           ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      x_r <= head.x;
      y_r <= head.y;
      c_r <= head.c;
      s_r <= head.s;
    end else if (advance) begin
      x_r <= x_r + ACC_W'(c_r);
      y_r <= y_r + ACC_W'(s_r);
    end
    if (emit) begin
      ox_r    <= to_coord(x_r);
      oy_r    <= to_coord(y_r);
      olast_r <= (bits_r[62:0] == '0);
    end
  end

  assign out_valid = ov_r;
  assign out_x     = ox_r;
  assign out_y     = oy_r;
  assign out_last  = olast_r;

endmodule

FILE: rtl/core/glyph_bitmap_rotated_blit_unit.sv
// Channel   Dir  tdata                                        tuser / tlast
// in_       in   pen_x,pen_y,left,right,up,down,advance,row   tuser = op
// out_      out  pixel_x, pixel_y                             tlast = last_of_row
// cfg_      in   write enable, index, 16-bit data             -
// The back end walks a row item one column per cycle up to its last set column
// (up to 64), holding on a set column while the output register is full; other
// items are handled in the front alone. Front and back run apart through a
// two-entry job queue; items flow back to back while the queue has room. Reset
// is synchronous, active low. The output register holds a pixel until out_tready.
`timescale 1ns / 1ps
`include "glyph_bitmap_rotated_blit_unit_defines.svh"
module glyph_bitmap_rotated_blit_unit import gbrb_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pen_x[15:0] pen_y[31:16] extent_left[39:32] extent_right[47:40]
  // extent_up[55:48] extent_down[63:56] advance[79:64] row_bits[143:80]
  input  logic [143:0] in_tdata,
  // op[1:0]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // pixel_x[15:0] pixel_y[31:16]
  output logic [31:0]  out_tdata,
  output logic         out_tlast,
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_wdata
);

  logic [2:0]         direction_r;
  logic signed [15:0] cos_q_r, sin_q_r;
  logic signed [15:0] vec_c, vec_s;

  job_t job, head;
  logic job_push, pop, empty, full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= DIR_RIGHT;
      cos_q_r     <= UNIT_ONE;
      sin_q_r     <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_DIRECTION: direction_r <= cfg_wdata[2:0];
        CFG_COS:       cos_q_r     <= cfg_wdata;
        CFG_SIN:       sin_q_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign vec_c = unit_c(direction_r, cos_q_r);
  assign vec_s = unit_s(direction_r, sin_q_r);

  gbrb_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .op           (in_tuser),
    .pen_x        (in_tdata[15:0]),
    .pen_y        (in_tdata[31:16]),
    .extent_left  (in_tdata[39:32]),
    .extent_right (in_tdata[47:40]),
    .extent_up    (in_tdata[55:48]),
    .extent_down  (in_tdata[63:56]),
    .advance      (in_tdata[79:64]),
    .row_bits     (in_tdata[143:80]),
    .vec_c        (vec_c),
    .vec_s        (vec_s),
    .job_push     (job_push),
    .job          (job),
    .fifo_full    (full)
  );

  gbrb_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (job),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  gbrb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_x     (out_tdata[15:0]),
    .out_y     (out_tdata[31:16]),
    .out_last  (out_tlast)
  );

  `GBRB_ASSERT_NEXT(a_reset_idle, clk, !rst_n, !out_tvalid && !empty == 1'b0)
  `GBRB_ASSERT_IMPL(a_no_push_full, clk, rst_n, job_push, !full)
  `GBRB_ASSERT_IMPL(a_no_pop_empty, clk, rst_n, pop, !empty)

endmodule
